FILE: sv/dim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dim_pkg
// Shared constants and register codes for the dilepton invariant mass block.
// ----------------------------------------------------------------------------
package dim_pkg;

  localparam int MOMENTUM_WIDTH_DEF = 24;
  localparam int MASS_SQ_WIDTH      = 21;
  localparam int CFG_INDEX_WIDTH    = 1;

  localparam logic [MASS_SQ_WIDTH-1:0] ELECTRON_MASS_SQ_RESET = 21'd0;
  localparam logic [MASS_SQ_WIDTH-1:0] MUON_MASS_SQ_RESET     = 21'd11712;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_ELECTRON_MASS_SQ = 1'b0,
    REG_MUON_MASS_SQ     = 1'b1
  } cfg_reg_t;

endpackage

FILE: sv/dim_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dim_sqrt
// Pipelined floor square root, one root bit per stage, several lanes that
// share valid and a side payload that travels alongside.
// ----------------------------------------------------------------------------
module dim_sqrt #(
  parameter int LANES = 1,
  parameter int RW    = 8,
  parameter int QW    = 4,
  parameter int SW    = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [RW-1:0] in_rad [LANES],
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_root [LANES],
  output logic [SW-1:0] out_side
);

  localparam int OW = 2 * QW;

  logic          vld  [QW+1];
  logic [OW-1:0] op   [QW+1][LANES];
  logic [OW-1:0] res  [QW+1][LANES];
  logic [SW-1:0] side [QW+1];

  assign vld[0]  = in_valid;
  assign side[0] = in_side;

  for (genvar l = 0; l < LANES; l++) begin : g_in
    assign op[0][l]  = OW'(in_rad[l]);
    assign res[0][l] = '0;
    assign out_root[l] = res[QW][l][QW-1:0];
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    // squared weight of the root bit settled in this stage
    localparam logic [OW-1:0] ONE = {{(OW-1){1'b0}}, 1'b1} << (2 * (QW - 1 - k));

    logic [OW-1:0] trial [LANES];
    logic          take  [LANES];

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = res[k][l] + ONE;
        take[l]  = (op[k][l] >= trial[l]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          op[k+1][l]  <= take[l] ? (op[k][l] - trial[l]) : op[k][l];
          res[k+1][l] <= take[l] ? ((res[k][l] >> 1) | ONE) : (res[k][l] >> 1);
        end
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_side  = side[QW];

endmodule

FILE: sv/dim_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dim_outbuf
// Output register with a skid slot; the pipeline halts only when the skid
// slot is occupied.
// ----------------------------------------------------------------------------
module dim_outbuf #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] in_data,
  output logic          en,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [DW-1:0] out_data
);

  logic          skid_valid;
  logic [DW-1:0] skid_data;
  logic          out_free;

  assign en       = !skid_valid;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (out_free) begin
      out_valid <= in_valid;
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        out_data <= skid_data;
      end
    end else if (out_free) begin
      if (in_valid) begin
        out_data <= in_data;
      end
    end else if (in_valid) begin
      skid_data <= in_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot holds data while output register is empty");

endmodule

FILE: sv/dilepton_invariant_mass.sv
`timescale 1ns / 1ps
// Throughput: one pair per cycle while the skid slot is empty; the two root pipelines
// settle one root bit per stage.
// A stalled output is absorbed by an output register plus one skid slot.
// Reset (rst, synchronous): clears all valid bits, electron mass squared to 0,
// muon mass squared to 11712.
// ----------------------------------------------------------------------------
// dilepton_invariant_mass
// Lepton energies, pair momentum, pair energy and invariant mass of a pair.
// ----------------------------------------------------------------------------
module dilepton_invariant_mass #(
  parameter int MOMENTUM_WIDTH = dim_pkg::MOMENTUM_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  // fields from bit 0: first_px, first_py, first_pz, second_px, second_py, second_pz
  input  logic [((6*MOMENTUM_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // fields from bit 0: kind
  input  logic [1:0] s_axis_tuser,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // fields from bit 0: pair_px, pair_py, pair_pz, pair_energy, pair_mass
  output logic [((5*(MOMENTUM_WIDTH+1)+7)/8)*8-1:0] m_axis_tdata,
  // fields from bit 0: mass_negative
  output logic [0:0] m_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [dim_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [dim_pkg::MASS_SQ_WIDTH-1:0] cfg_data
);

  localparam int W        = MOMENTUM_WIDTH;
  localparam int PW       = W + 1;
  localparam int SQ       = 2 * W;
  localparam int ER       = 2 * W + 1;
  localparam int EQ       = W + 1;
  localparam int ES       = W + 2;
  localparam int PSQ      = 2 * W + 2;
  localparam int TOT      = 2 * W + 4;
  localparam int MQ       = W + 2;
  localparam int MSQ      = dim_pkg::MASS_SQ_WIDTH;
  localparam int OUT_BITS = 5 * PW;
  localparam int OUT_DW   = ((OUT_BITS + 7) / 8) * 8;
  localparam int ESIDE    = 3 * PW + 3 * PSQ;
  localparam int MSIDE    = 1 + 4 * PW;

  // configuration registers
  logic [MSQ-1:0] electron_mass_sq;
  logic [MSQ-1:0] muon_mass_sq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      electron_mass_sq <= dim_pkg::ELECTRON_MASS_SQ_RESET;
      muon_mass_sq     <= dim_pkg::MUON_MASS_SQ_RESET;
    end else if (cfg_valid) begin
      unique case (dim_pkg::cfg_reg_t'(cfg_index))
        dim_pkg::REG_ELECTRON_MASS_SQ: electron_mass_sq <= cfg_data;
        dim_pkg::REG_MUON_MASS_SQ:     muon_mass_sq     <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign s_axis_tready = en;

  logic [W-1:0] mom_in [6];
  for (genvar i = 0; i < 6; i++) begin : g_unpack
    assign mom_in[i] = s_axis_tdata[i*W +: W];
  end

  // stage 1: magnitudes, pair sums, mass selection
  logic           v1;
  logic [W-1:0]   mag1 [6];
  logic [PW-1:0]  psum1 [3];
  logic [MSQ-1:0] msq_a1, msq_b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        mag1[i] <= mom_in[i][W-1] ? (~mom_in[i] + 1'b1) : mom_in[i];
      end
      for (int j = 0; j < 3; j++) begin
        psum1[j] <= {mom_in[j][W-1], mom_in[j]} + {mom_in[j+3][W-1], mom_in[j+3]};
      end
      msq_a1 <= s_axis_tuser[1] ? muon_mass_sq : electron_mass_sq;
      msq_b1 <= s_axis_tuser[0] ? muon_mass_sq : electron_mass_sq;
    end
  end

  // stage 2: squared components, pair magnitudes
  logic           v2;
  logic [SQ-1:0]  sq2 [6];
  logic [PW-1:0]  psum2 [3];
  logic [PW-1:0]  pmag2 [3];
  logic [MSQ-1:0] msq_a2, msq_b2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        sq2[i] <= SQ'(mag1[i]) * SQ'(mag1[i]);
      end
      for (int j = 0; j < 3; j++) begin
        psum2[j] <= psum1[j];
        pmag2[j] <= psum1[j][PW-1] ? (~psum1[j] + 1'b1) : psum1[j];
      end
      msq_a2 <= msq_a1;
      msq_b2 <= msq_b1;
    end
  end

  // stage 3: energy radicands, squared pair components
  logic          v3;
  logic [ER-1:0] rad3 [2];
  logic [PW-1:0] psum3 [3];
  logic [PSQ-1:0] psq3 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad3[0] <= ER'(sq2[0]) + ER'(sq2[1]) + ER'(sq2[2]) + ER'(msq_a2);
      rad3[1] <= ER'(sq2[3]) + ER'(sq2[4]) + ER'(sq2[5]) + ER'(msq_b2);
      for (int j = 0; j < 3; j++) begin
        psum3[j] <= psum2[j];
        psq3[j]  <= PSQ'(pmag2[j]) * PSQ'(pmag2[j]);
      end
    end
  end

  // lepton energies
  logic             ve;
  logic [EQ-1:0]    energy [2];
  logic [ESIDE-1:0] eside_in, eside_out;

  assign eside_in = {psq3[2], psq3[1], psq3[0], psum3[2], psum3[1], psum3[0]};

  dim_sqrt #(
    .LANES (2),
    .RW    (ER),
    .QW    (EQ),
    .SW    (ESIDE)
  ) u_energy_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .in_rad    (rad3),
    .in_side   (eside_in),
    .out_valid (ve),
    .out_root  (energy),
    .out_side  (eside_out)
  );

  // stage 5: energy sum, momentum squared sum
  logic          v5;
  logic [ES-1:0] esum5;
  logic [TOT-1:0] psqsum5;
  logic [3*PW-1:0] psum5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      esum5   <= ES'(energy[0]) + ES'(energy[1]);
      psqsum5 <= TOT'(eside_out[3*PW +: PSQ]) + TOT'(eside_out[3*PW+PSQ +: PSQ])
               + TOT'(eside_out[3*PW+2*PSQ +: PSQ]);
      psum5   <= eside_out[3*PW-1:0];
    end
  end

  // stage 6: energy squared
  logic           v6;
  logic [TOT-1:0] esq6;
  logic [TOT-1:0] psqsum6;
  logic [ES-1:0]  esum6;
  logic [3*PW-1:0] psum6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      esq6    <= TOT'(esum5) * TOT'(esum5);
      psqsum6 <= psqsum5;
      esum6   <= esum5;
      psum6   <= psum5;
    end
  end

  // stage 7: mass radicand, sign check, energy saturation
  logic           v7;
  logic [TOT-1:0] rad7;
  logic           neg7;
  logic [PW-1:0]  energy_sat7;
  logic [3*PW-1:0] psum7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg7        <= (psqsum6 > esq6);
      rad7        <= (psqsum6 > esq6) ? '0 : (esq6 - psqsum6);
      energy_sat7 <= esum6[ES-1] ? {PW{1'b1}} : esum6[PW-1:0];
      psum7       <= psum6;
    end
  end

  // invariant mass
  logic             vm;
  logic [MQ-1:0]    mass_root [1];
  logic [TOT-1:0]   mrad [1];
  logic [MSIDE-1:0] mside_in, mside_out;
  logic [PW-1:0]    mass_sat;

  assign mrad[0]  = rad7;
  assign mside_in = {neg7, energy_sat7, psum7};

  dim_sqrt #(
    .LANES (1),
    .RW    (TOT),
    .QW    (MQ),
    .SW    (MSIDE)
  ) u_mass_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .in_rad    (mrad),
    .in_side   (mside_in),
    .out_valid (vm),
    .out_root  (mass_root),
    .out_side  (mside_out)
  );

  assign mass_sat = mass_root[0][MQ-1] ? {PW{1'b1}} : mass_root[0][PW-1:0];

  logic [OUT_BITS:0] ob_in, ob_out;

  // top bit carries the negative radicand flag
  assign ob_in = {mside_out[MSIDE-1], mass_sat, mside_out[4*PW-1:0]};

  dim_outbuf #(
    .DW (OUT_BITS + 1)
  ) u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vm),
    .in_data   (ob_in),
    .en        (en),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (ob_out)
  );

  assign m_axis_tdata = OUT_DW'(ob_out[OUT_BITS-1:0]);
  assign m_axis_tuser = ob_out[OUT_BITS];

  a_neg_mass_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[5*PW-1:4*PW] == '0))
    else $error("negative radicand flagged with non-zero mass");

  a_mass_le_energy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[5*PW-1:4*PW] <= m_axis_tdata[4*PW-1:3*PW]))
    else $error("invariant mass exceeds pair energy");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |=> ($stable(v1) && $stable(v7)))
    else $error("pipeline moved while halted");

endmodule
